>>> src/rnf_pkg.sv
// Shared constants, types and codes for the rotation novelty filter.
package rnf_pkg;

    localparam int ELEM_W      = 16;
    localparam int NUM_ELEMS   = 9;
    localparam int ELEM_IDX_W  = 4;
    localparam int MAX_VIEWS   = 256;
    localparam int COUNT_W     = 9;
    localparam int STORE_DEPTH = MAX_VIEWS * NUM_ELEMS;
    localparam int ADDR_W      = 12;
    localparam int FRAC_BITS   = 14;
    localparam int LIMIT_W     = 17;
    localparam int TARGET_W    = 8;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = 36;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TARGET = 1'b1;

    localparam logic [LIMIT_W-1:0]  TRACE_LIMIT_RESET = 17'd49121;
    localparam logic [TARGET_W-1:0] VIEW_TARGET_RESET = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_DRAIN,
        ST_WRITE
    } rnf_state_t;

    // Control that travels with one operand pair into the accumulate unit.
    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } rnf_mac_ctl_t;

endpackage

>>> src/rnf_view_mem.sv
// Stored view memory: one write port and one registered read port.
module rnf_view_mem (
    input  logic                               clk,
    input  logic                               we,
    input  logic [rnf_pkg::ADDR_W-1:0]         waddr,
    input  logic signed [rnf_pkg::ELEM_W-1:0]  wdata,
    input  logic [rnf_pkg::ADDR_W-1:0]         raddr,
    output logic signed [rnf_pkg::ELEM_W-1:0]  rdata
);

    logic signed [rnf_pkg::ELEM_W-1:0] mem [rnf_pkg::STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/rnf_mac.sv
// Shared multiply-accumulate unit that forms each trace and tests it against the limit.
module rnf_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rnf_pkg::rnf_mac_ctl_t              ctl,
    input  logic signed [rnf_pkg::ELEM_W-1:0]  elem,
    input  logic signed [rnf_pkg::ELEM_W-1:0]  view,
    input  logic signed [rnf_pkg::ACC_W-1:0]   limit,
    output logic                               pending,
    output logic                               hit
);

    logic signed [rnf_pkg::PROD_W-1:0] prod_reg;
    logic                              p_valid_reg;
    logic                              p_last_reg;
    logic signed [rnf_pkg::ACC_W-1:0]  acc_reg;
    logic signed [rnf_pkg::ACC_W-1:0]  acc_next;
    logic                              hit_reg;
    logic                              hit_next;
    logic signed [rnf_pkg::ACC_W-1:0]  sum;

    assign sum = acc_reg
               + {{(rnf_pkg::ACC_W - rnf_pkg::PROD_W){prod_reg[rnf_pkg::PROD_W-1]}}, prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        hit_next = hit_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
            hit_next = 1'b0;
        end
        else if (p_valid_reg)
        begin
            if (p_last_reg)
            begin
                // The trace of one stored view is complete here.
                acc_next = '0;
                hit_next = hit_reg | (sum >= limit);
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= elem * view;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            acc_reg     <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            p_valid_reg <= ctl.valid;
            p_last_reg  <= ctl.last;
            acc_reg     <= acc_next;
            hit_reg     <= hit_next;
        end
    end

    assign pending = p_valid_reg;
    assign hit     = hit_reg;

endmodule

>>> src/rotation_novelty_filter_unit.sv
// Top level of the rotation novelty filter: sequencer, registers and result port.
// A rotation beat is taken at a rising edge where start is high and busy is low;
// pose_valid, clear_store and r00..r22 are sampled at that edge.
// Exactly one result beat follows each item: result_valid is high for one cycle
// with novel, satisfied and store_full, and the receiver cannot hold it off.
// An item with pose_valid low gives an all-zero result in the next cycle.
// A valid item is compared with all N stored views, one matrix element per cycle
// through a single multiplier and the single read port of the view memory, and
// the pipeline then drains. A novel item that fits is then written back.
// Busy is high from acceptance until the result appears, and a new item may
// be started in the result cycle.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at once
// and are to be made only while busy is low; the block does not enforce this.
// Reset empties the store (the view count goes to zero), restores both
// configuration registers and drops busy and result_valid.
module rotation_novelty_filter_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [rnf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rnf_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   pose_valid,
    input  logic                                   clear_store,
    input  logic signed [rnf_pkg::ELEM_W-1:0]      r00,
    input  logic signed [rnf_pkg::ELEM_W-1:0]      r01,
    input  logic signed [rnf_pkg::ELEM_W-1:0]      r02,
    input  logic signed [rnf_pkg::ELEM_W-1:0]      r10,
    input  logic signed [rnf_pkg::ELEM_W-1:0]      r11,
    input  logic signed [rnf_pkg::ELEM_W-1:0]      r12,
    input  logic signed [rnf_pkg::ELEM_W-1:0]      r20,
    input  logic signed [rnf_pkg::ELEM_W-1:0]      r21,
    input  logic signed [rnf_pkg::ELEM_W-1:0]      r22,
    output logic                                   result_valid,
    output logic                                   novel,
    output logic                                   satisfied,
    output logic                                   store_full
);

    localparam int LIMIT_PAD = rnf_pkg::ACC_W - rnf_pkg::LIMIT_W - rnf_pkg::FRAC_BITS;

    rnf_pkg::rnf_state_t state_reg, state_next;

    logic [rnf_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [rnf_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic [rnf_pkg::ELEM_IDX_W-1:0]    k_reg, k_next;
    logic                              s1_valid_reg, s1_valid_next;
    logic                              s1_last_reg, s1_last_next;
    logic [rnf_pkg::ELEM_IDX_W-1:0]    s1_k_reg;
    logic [rnf_pkg::LIMIT_W-1:0]       trace_limit_reg;
    logic [rnf_pkg::TARGET_W-1:0]      view_target_reg;
    logic                              result_valid_reg, result_valid_next;
    logic                              novel_reg, novel_next;
    logic                              satisfied_reg, satisfied_next;
    logic                              store_full_reg, store_full_next;
    logic signed [rnf_pkg::ELEM_W-1:0] rot_reg [rnf_pkg::NUM_ELEMS];

    logic                              accept;
    logic [rnf_pkg::ADDR_W-1:0]        end_addr;
    logic [rnf_pkg::ELEM_IDX_W-1:0]    rot_idx;
    logic signed [rnf_pkg::ELEM_W-1:0] rot_sel;
    logic signed [rnf_pkg::ELEM_W-1:0] view_rdata;
    logic signed [rnf_pkg::ACC_W-1:0]  limit_q;
    logic                              mem_we;
    logic                              mac_pending;
    logic                              mac_hit;
    rnf_pkg::rnf_mac_ctl_t             mac_ctl;
    logic [rnf_pkg::COUNT_W-1:0]       count_inc;

    assign accept   = start && (state_reg == rnf_pkg::ST_IDLE);
    assign end_addr = rnf_pkg::ADDR_W'({count_reg, 3'b000}) + rnf_pkg::ADDR_W'(count_reg);
    assign limit_q  = {{LIMIT_PAD{trace_limit_reg[rnf_pkg::LIMIT_W-1]}},
                       trace_limit_reg, {rnf_pkg::FRAC_BITS{1'b0}}};
    assign count_inc = count_reg + rnf_pkg::COUNT_W'(1);

    // One element select serves both the multiplier and the write-back data.
    assign rot_idx = (state_reg == rnf_pkg::ST_WRITE) ? k_reg : s1_k_reg;
    assign rot_sel = rot_reg[rot_idx];
    assign mem_we  = (state_reg == rnf_pkg::ST_WRITE);

    assign mac_ctl.clear = accept;
    assign mac_ctl.valid = s1_valid_reg;
    assign mac_ctl.last  = s1_last_reg;

    rnf_view_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (rot_sel),
        .raddr (addr_reg),
        .rdata (view_rdata)
    );

    rnf_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .elem    (rot_sel),
        .view    (view_rdata),
        .limit   (limit_q),
        .pending (mac_pending),
        .hit     (mac_hit)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        addr_next         = addr_reg;
        k_next            = k_reg;
        s1_valid_next     = 1'b0;
        s1_last_next      = 1'b0;
        result_valid_next = 1'b0;
        novel_next        = novel_reg;
        satisfied_next    = satisfied_reg;
        store_full_next   = store_full_reg;

        unique case (state_reg)
            rnf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    addr_next = '0;
                    k_next    = '0;
                    if (pose_valid)
                    begin
                        if (clear_store)
                        begin
                            count_next = '0;
                        end
                        state_next = rnf_pkg::ST_COMPARE;
                    end
                    else
                    begin
                        result_valid_next = 1'b1;
                        novel_next        = 1'b0;
                        satisfied_next    = 1'b0;
                        store_full_next   = 1'b0;
                    end
                end
            end
            rnf_pkg::ST_COMPARE:
            begin
                if (addr_reg == end_addr)
                begin
                    state_next = rnf_pkg::ST_DRAIN;
                end
                else
                begin
                    s1_valid_next = 1'b1;
                    s1_last_next  = (k_reg == rnf_pkg::ELEM_IDX_W'(rnf_pkg::NUM_ELEMS - 1));
                    addr_next     = addr_reg + rnf_pkg::ADDR_W'(1);
                    k_next        = s1_last_next ? '0 : k_reg + rnf_pkg::ELEM_IDX_W'(1);
                end
            end
            rnf_pkg::ST_DRAIN:
            begin
                // The hit flag is final once the read and multiply stages are empty.
                if (!s1_valid_reg && !mac_pending)
                begin
                    if (!mac_hit && (count_reg != rnf_pkg::COUNT_W'(rnf_pkg::MAX_VIEWS)))
                    begin
                        state_next = rnf_pkg::ST_WRITE;
                    end
                    else
                    begin
                        state_next        = rnf_pkg::ST_IDLE;
                        result_valid_next = 1'b1;
                        novel_next        = !mac_hit;
                        satisfied_next    = 1'b0;
                        store_full_next   = !mac_hit;
                    end
                end
            end
            rnf_pkg::ST_WRITE:
            begin
                addr_next = addr_reg + rnf_pkg::ADDR_W'(1);
                k_next    = k_reg + rnf_pkg::ELEM_IDX_W'(1);
                if (k_reg == rnf_pkg::ELEM_IDX_W'(rnf_pkg::NUM_ELEMS - 1))
                begin
                    state_next        = rnf_pkg::ST_IDLE;
                    count_next        = count_inc;
                    result_valid_next = 1'b1;
                    novel_next        = 1'b1;
                    satisfied_next    = count_inc > rnf_pkg::COUNT_W'(view_target_reg);
                    store_full_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = rnf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rnf_pkg::ST_IDLE;
            count_reg        <= '0;
            addr_reg         <= '0;
            k_reg            <= '0;
            s1_valid_reg     <= 1'b0;
            s1_last_reg      <= 1'b0;
            s1_k_reg         <= '0;
            result_valid_reg <= 1'b0;
            novel_reg        <= 1'b0;
            satisfied_reg    <= 1'b0;
            store_full_reg   <= 1'b0;
            trace_limit_reg  <= rnf_pkg::TRACE_LIMIT_RESET;
            view_target_reg  <= rnf_pkg::VIEW_TARGET_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            addr_reg         <= addr_next;
            k_reg            <= k_next;
            s1_valid_reg     <= s1_valid_next;
            s1_last_reg      <= s1_last_next;
            s1_k_reg         <= k_reg;
            result_valid_reg <= result_valid_next;
            novel_reg        <= novel_next;
            satisfied_reg    <= satisfied_next;
            store_full_reg   <= store_full_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rnf_pkg::CFG_TRACE_LIMIT: trace_limit_reg <= cfg_data;
                    rnf_pkg::CFG_VIEW_TARGET: view_target_reg <= cfg_data[rnf_pkg::TARGET_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rot_reg[0] <= r00;
            rot_reg[1] <= r01;
            rot_reg[2] <= r02;
            rot_reg[3] <= r10;
            rot_reg[4] <= r11;
            rot_reg[5] <= r12;
            rot_reg[6] <= r20;
            rot_reg[7] <= r21;
            rot_reg[8] <= r22;
        end
    end

    assign busy         = (state_reg != rnf_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign novel        = novel_reg;
    assign satisfied    = satisfied_reg;
    assign store_full   = store_full_reg;

    a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && store_full |-> novel && !satisfied)
        else $error("store_full without novel, or with satisfied");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rnf_pkg::COUNT_W'(rnf_pkg::MAX_VIEWS))
        else $error("view count beyond store size");

    a_invalid_item: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !pose_valid |=> result_valid && !novel && !satisfied && !store_full)
        else $error("invalid item did not give an immediate zero result");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy && !s1_valid_reg && !mac_pending)
        else $error("result shown while the compare pipeline is still active");

endmodule
